>>> sv/bmrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap range and search engine.
// No dependencies; imported by the top level.
package bmrs_pkg;

   localparam int MAX_BITS_DEF  = 1024;
   localparam int WORD_BITS_DEF = 32;

   localparam int KIND_W   = 4;
   localparam int IDX_W    = 10;
   localparam int CAP_W    = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [KIND_W-1:0] {
      KIND_READ         = 4'd0,
      KIND_SET          = 4'd1,
      KIND_CLEAR        = 4'd2,
      KIND_TOGGLE       = 4'd3,
      KIND_CLEAR_RANGE  = 4'd4,
      KIND_SET_RANGE    = 4'd5,
      KIND_TOGGLE_RANGE = 4'd6,
      KIND_FIRST_FREE   = 4'd7,
      KIND_LAST_FREE    = 4'd8,
      KIND_FIRST_BUSY   = 4'd9,
      KIND_LAST_BUSY    = 4'd10
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

>>> sv/bmrs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/bitmap_range_and_search_engine.sv
`timescale 1ns / 1ps
// Bitmap range and search engine: word-walking sequencer over a bitmap RAM.
// Depends on bmrs_pkg and bmrs_ram.
//
// Channel  Dir  Handshake             Payload
// req      in   req_tvalid/tready     tuser = kind, tdata = start_index, end_index
// rsp      out  rsp_tvalid/tready     tuser = status, found; tdata = bit_value, found_index
// csr      in   csr_wr_en             csr_wr_data = capacity
//
// One request walks the store one word per cycle through a single
// read-modify-write path. Single-bit kinds visit one word, range kinds one
// per covered word, searches up to MAX_BITS/WORD_BITS words, stopping at the
// first hit. Rejected and unused kinds go straight to the finish state.
// Reset clears per-word valid bits at once; no clearing pass is needed.
// req_tready is low while a request is being walked; a finished result waits
// in the output register while the next request is taken.
// WORD_BITS must be a power of two.
module bitmap_range_and_search_engine
   import bmrs_pkg::*;
#(
   parameter int MAX_BITS  = MAX_BITS_DEF,
   parameter int WORD_BITS = WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // start_index[9:0], end_index[19:10], zero pad
   input  logic [KIND_W-1:0]     req_tuser,  // kind[3:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // bit_value[0], found_index[10:1], zero pad
   output logic [RSP_USER_W-1:0] rsp_tuser,  // status[0], found[1]
   input  logic                  csr_wr_en,
   input  logic [CAP_W-1:0]      csr_wr_data
);

   localparam int WORDS    = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int OW       = $clog2(WORD_BITS);
   localparam int GW       = AW + OW;
   localparam int CapLimit = (MAX_BITS > 2047) ? 2047 : MAX_BITS;
   localparam logic [OW-1:0]        TopBit = OW'(WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] Ones   = '1;

   state_type             state_ff, state_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [GW-1:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [AW-1:0]         last_addr_ff, last_addr_in;
   logic [AW-1:0]         rd_addr_ff, rd_addr_in;
   logic                  down_ff, down_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic                  res_status_ff, res_status_in;
   logic                  res_bit_ff, res_bit_in;
   logic                  res_found_ff, res_found_in;
   logic [IDX_W-1:0]      res_index_ff, res_index_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;
   logic [CAP_W-1:0]      cap_ff;
   logic [WORDS-1:0]      word_valid_ff;

   logic [CAP_W-1:0]      cap_live, cap_m1;
   logic [IDX_W-1:0]      req_start, req_end;
   logic                  rd_en, wr_en;
   logic [WORD_BITS-1:0]  ram_q, word_data, wr_data, mask, cand;
   logic [OW-1:0]         lo_off, hi_off, pos_low, pos_high;
   logic                  want;

   assign req_start = req_tdata[IDX_W-1:0];
   assign req_end   = req_tdata[2*IDX_W-1:IDX_W];
   assign cap_live  = (cap_ff > CAP_W'(CapLimit)) ? CAP_W'(CapLimit) : cap_ff;
   assign cap_m1    = cap_live - CAP_W'(1);

   bmrs_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pend_addr_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_q)
   );

   // Word under test, masked to the active bit span of this request
   always_comb begin
      word_data = pend_valid_ff ? ram_q : '0;
      lo_off = (pend_addr_ff == lo_ff[GW-1:OW]) ? lo_ff[OW-1:0] : '0;
      hi_off = (pend_addr_ff == hi_ff[GW-1:OW]) ? hi_ff[OW-1:0] : TopBit;
      mask   = (Ones << lo_off) & (Ones >> (TopBit - hi_off));
      want   = (kind_ff == KIND_FIRST_BUSY) || (kind_ff == KIND_LAST_BUSY);
      cand   = (want ? word_data : ~word_data) & mask;
      pos_low  = '0;
      pos_high = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (cand[i]) pos_low = OW'(i);
      end
      for (int i = 0; i < WORD_BITS; i++) begin
         if (cand[i]) pos_high = OW'(i);
      end
   end

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      last_addr_in  = last_addr_ff;
      rd_addr_in    = rd_addr_ff;
      down_in       = down_ff;
      issue_done_in = issue_done_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      pend_valid_in = pend_valid_ff;
      res_status_in = res_status_ff;
      res_bit_in    = res_bit_ff;
      res_found_in  = res_found_ff;
      res_index_in  = res_index_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;
      req_tready    = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_data       = word_data;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               kind_in       = req_tuser;
               res_status_in = 1'b0;
               res_bit_in    = 1'b0;
               res_found_in  = 1'b0;
               res_index_in  = '0;
               issue_done_in = 1'b0;
               down_in       = 1'b0;
               lo_in         = GW'(req_start);
               hi_in         = GW'(req_start);
               state_in      = ST_WALK;
               unique case (req_tuser) inside
                  KIND_READ, KIND_SET, KIND_CLEAR, KIND_TOGGLE: begin
                     if ({1'b0, req_start} >= cap_live) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end
                  end
                  KIND_CLEAR_RANGE, KIND_SET_RANGE, KIND_TOGGLE_RANGE: begin
                     hi_in = GW'(req_end);
                     if (req_end < req_start || {1'b0, req_end} >= cap_live) begin
                        res_status_in = 1'b1;
                        state_in      = ST_DONE;
                     end
                  end
                  KIND_FIRST_FREE, KIND_FIRST_BUSY, KIND_LAST_FREE, KIND_LAST_BUSY: begin
                     lo_in   = '0;
                     hi_in   = GW'(cap_m1);
                     down_in = (req_tuser == KIND_LAST_FREE) || (req_tuser == KIND_LAST_BUSY);
                     if (cap_live == '0) state_in = ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
               // walk from the lower word up, or from the upper word down
               rd_addr_in   = down_in ? hi_in[GW-1:OW] : lo_in[GW-1:OW];
               last_addr_in = down_in ? lo_in[GW-1:OW] : hi_in[GW-1:OW];
            end
         end

         ST_WALK: begin
            if (!issue_done_ff) begin
               rd_en         = 1'b1;
               pend_in       = 1'b1;
               pend_addr_in  = rd_addr_ff;
               pend_valid_in = word_valid_ff[rd_addr_ff];
               if (rd_addr_ff == last_addr_ff) begin
                  issue_done_in = 1'b1;
               end else begin
                  rd_addr_in = down_ff ? rd_addr_ff - AW'(1) : rd_addr_ff + AW'(1);
               end
            end
            if (pend_ff) begin
               case (kind_ff) inside
                  KIND_READ: begin
                     res_bit_in = |(word_data & mask);
                  end
                  KIND_SET, KIND_SET_RANGE: begin
                     wr_en   = 1'b1;
                     wr_data = word_data | mask;
                  end
                  KIND_CLEAR, KIND_CLEAR_RANGE: begin
                     wr_en   = 1'b1;
                     wr_data = word_data & ~mask;
                  end
                  KIND_TOGGLE, KIND_TOGGLE_RANGE: begin
                     wr_en   = 1'b1;
                     wr_data = word_data ^ mask;
                  end
                  default: begin
                     if (|cand) begin
                        res_found_in = 1'b1;
                        res_index_in = IDX_W'({pend_addr_ff, down_ff ? pos_high : pos_low});
                     end
                  end
               endcase
               if (pend_addr_ff == last_addr_ff || |res_found_in) begin
                  state_in = ST_DONE;
               end
            end
         end

         ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({res_index_ff, res_bit_ff});
               rsp_user_in  = {res_found_ff, res_status_ff};
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pend_ff       <= 1'b0;
         issue_done_ff <= 1'b0;
         cap_ff        <= CAP_RESET;
         word_valid_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_ff       <= pend_in;
         issue_done_ff <= issue_done_in;
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (wr_en) word_valid_ff[pend_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      kind_in_reg: begin
         kind_ff       <= kind_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         last_addr_ff  <= last_addr_in;
         rd_addr_ff    <= rd_addr_in;
         down_ff       <= down_in;
         pend_addr_ff  <= pend_addr_in;
         pend_valid_ff <= pend_valid_in;
         res_status_ff <= res_status_in;
         res_bit_ff    <= res_bit_in;
         res_found_ff  <= res_found_in;
         res_index_ff  <= res_index_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_user_ff   <= rsp_user_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Store writes only come from modifying kinds inside a walk
   a_write_kind: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == ST_WALK && kind_ff >= KIND_SET && kind_ff <= KIND_TOGGLE_RANGE)
      else $error("store write outside a modifying walk");

   // A new result only appears after the finish state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside finish state");

   // A rejected request reports nothing else
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_user_ff[0] |-> !rsp_user_ff[1] && rsp_data_ff == '0)
      else $error("out-of-range result carries data");

   // The walk never runs past its end word
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WALK && pend_ff |->
         (down_ff ? pend_addr_ff >= last_addr_ff : pend_addr_ff <= last_addr_ff))
      else $error("walk overran its end word");

endmodule
